### rtl/core/ia2d_pkg.sv
// ----------------------------------------------------------------------------
// ia2d_pkg
// Shared types, constants and the stepped correction table for the integer
// bearing core.
// ----------------------------------------------------------------------------
package ia2d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int QUO_BITS       = 6;   // ratio * 45 lies in 0..45
  localparam int ANGLE_BITS     = 9;

  // Correction thresholds
  localparam logic [QUO_BITS-1:0] CORR_MID = 6'd22;
  localparam logic [QUO_BITS-1:0] CORR_H1  = 6'd44;
  localparam logic [QUO_BITS-1:0] CORR_H2  = 6'd41;
  localparam logic [QUO_BITS-1:0] CORR_H3  = 6'd37;
  localparam logic [QUO_BITS-1:0] CORR_H4  = 6'd32;
  localparam logic [QUO_BITS-1:0] CORR_L1  = 6'd2;
  localparam logic [QUO_BITS-1:0] CORR_L2  = 6'd6;
  localparam logic [QUO_BITS-1:0] CORR_L3  = 6'd10;
  localparam logic [QUO_BITS-1:0] CORR_L4  = 6'd15;
  localparam logic [QUO_BITS-1:0] QUO_MAX  = 6'd45;

  // Octant and quadrant information that rides alongside the division
  typedef struct packed {
    logic wide;   // |x| > |y|
    logic yneg;
    logic xneg;
    logic zero;   // both magnitudes zero
  } ia2d_side_t;

  function automatic logic [2:0] ia2d_corr(input logic [QUO_BITS-1:0] a);
    logic [2:0] c;
    c = 3'd0;
    if (a > CORR_MID) begin
      c = 3'(a <= CORR_H1) + 3'(a <= CORR_H2) + 3'(a <= CORR_H3) + 3'(a <= CORR_H4);
    end else begin
      c = 3'(a >= CORR_L1) + 3'(a >= CORR_L2) + 3'(a >= CORR_L3) + 3'(a >= CORR_L4);
    end
    return c;
  endfunction

endpackage

### rtl/core/ia2d_div.sv
// ----------------------------------------------------------------------------
// ia2d_div
// Pipelined restoring divider, one quotient bit per register stage, with
// valid bits and a per-stage stall chain.
// ----------------------------------------------------------------------------
module ia2d_div import ia2d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [COORD_BITS+4:0]     rem_i,
  input  logic [COORD_BITS+4:0]     den_i,
  input  ia2d_side_t                side_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [QUO_BITS-1:0]       quo_o,
  output ia2d_side_t                side_o
);

  localparam int RW = COORD_BITS + 5;
  localparam int QB = QUO_BITS;

  logic [QB-1:0]   vld_q;
  logic [QB-1:0]   en;
  logic [RW-1:0]   rem_q  [0:QB-2];
  logic [RW-1:0]   den_q  [0:QB-2];
  logic [QB-1:0]   quo_q  [0:QB-1];
  ia2d_side_t      side_q [0:QB-1];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] rem_in, den_in, trial;
    logic [QB-1:0] quo_in;
    ia2d_side_t    side_in;
    logic          vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    if (k == QB - 1) begin : g_en_last
      assign en[k] = !vld_q[k] || !stall_i;
    end else begin : g_en_mid
      assign en[k] = !vld_q[k] || en[k+1];
    end

    assign trial = den_in << SH;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && vld_in) begin
        quo_q[k]  <= {quo_in[QB-2:0], ge};
        side_q[k] <= side_in;
      end
    end

    // Last stage only needs the quotient
    if (k < QB - 1) begin : g_carry
      logic [RW-1:0] rem_d;

      assign rem_d = ge ? (rem_in - trial) : rem_in;

      always_ff @(posedge clk_i) begin
        if (en[k] && vld_in) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

### rtl/core/integer_atan2_degrees_core.sv
// ----------------------------------------------------------------------------
// integer_atan2_degrees_core
// Bearing of a signed (x, y) vector in whole degrees, 0 along +Y, growing
// clockwise toward +X, 0..360, within about one degree.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                    | Beat payload
//  --------+-----------+------------------------------+---------------------
//  in      | sink      | in_valid_i / in_stall_o      | vec_y_i, vec_x_i
//  out     | source    | out_valid_o / out_stall_i    | angle_deg_o
//
//  One beat per cycle while out_stall_i is low; nine register stages
//  (magnitude, times-45, six divider bit stages, fold/output) lie between
//  vec_y_i/vec_x_i and angle_deg_o.
//  The six-stage restoring divider sets the depth: one quotient bit a stage.
//  rst_ni clears the valid bits of every stage; payload is not reset.
//  Each stage holds while its successor is full and stalled, so bubbles are
//  squeezed out and a stall loses or repeats no beat.
//
module integer_atan2_degrees_core import ia2d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] vec_y_i,
  input  logic signed [COORD_BITS-1:0] vec_x_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ANGLE_BITS-1:0]        angle_deg_o
);

  localparam int MW = COORD_BITS - 1;  // magnitude width after saturation
  localparam int RW = COORD_BITS + 5;  // holds min * 45

  localparam logic [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [MW-1:0]         MAG_MAX  = {MW{1'b1}};

  localparam logic [ANGLE_BITS-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_BITS-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_BITS-1:0] DEG_360 = 9'd360;

  // --------------------------------------------------------------------------
  // Stage A: magnitudes with saturation, order them, note the octant
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] neg_y, neg_x;
  logic [MW-1:0]         mag_y, mag_x;
  logic                  en_a, en_b;
  logic                  a_valid_q;
  logic [MW-1:0]         a_min_q, a_max_q;
  ia2d_side_t            a_side_q;
  ia2d_side_t            side_a_d;

  assign neg_y = -vec_y_i;
  assign neg_x = -vec_x_i;

  always_comb begin
    if (!vec_y_i[COORD_BITS-1]) begin
      mag_y = vec_y_i[MW-1:0];
    end else if (vec_y_i == MOST_NEG) begin
      mag_y = MAG_MAX;
    end else begin
      mag_y = neg_y[MW-1:0];
    end
    if (!vec_x_i[COORD_BITS-1]) begin
      mag_x = vec_x_i[MW-1:0];
    end else if (vec_x_i == MOST_NEG) begin
      mag_x = MAG_MAX;
    end else begin
      mag_x = neg_x[MW-1:0];
    end
    side_a_d.wide = (mag_x > mag_y);
    side_a_d.yneg = vec_y_i[COORD_BITS-1];
    side_a_d.xneg = vec_x_i[COORD_BITS-1];
    side_a_d.zero = (mag_x == '0) && (mag_y == '0);
  end

  assign en_a       = !a_valid_q || en_b;
  assign in_stall_o = !en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_a) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a_min_q  <= side_a_d.wide ? mag_y : mag_x;
      a_max_q  <= side_a_d.wide ? mag_x : mag_y;
      a_side_q <= side_a_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: numerator = min * 45 by shift and add
  // --------------------------------------------------------------------------
  logic          b_valid_q;
  logic [RW-1:0] b_num_q, b_den_q;
  ia2d_side_t    b_side_q;
  logic [RW-1:0] min_ext, num_d;
  logic          div_stall;

  assign min_ext = RW'(a_min_q);
  assign num_d   = (min_ext << 5) + (min_ext << 3) + (min_ext << 2) + min_ext;
  assign en_b    = !b_valid_q || !div_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && a_valid_q) begin
      b_num_q  <= num_d;
      b_den_q  <= RW'(a_max_q);
      b_side_q <= a_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: six stages; nonzero vectors give quotient 0..45 since min <= max
  // --------------------------------------------------------------------------
  logic                div_valid;
  logic [QUO_BITS-1:0] div_quo;
  ia2d_side_t          div_side;
  logic                en_f;

  ia2d_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .stall_o (div_stall),
    .rem_i   (b_num_q),
    .den_i   (b_den_q),
    .side_i  (b_side_q),
    .valid_o (div_valid),
    .stall_i (!en_f),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: correction, octant mirror, quadrant fold
  // --------------------------------------------------------------------------
  logic [QUO_BITS-1:0]   adj;
  logic [ANGLE_BITS-1:0] oct, angle_d;
  logic                  out_valid_q;
  logic [ANGLE_BITS-1:0] angle_q;

  always_comb begin
    adj = div_quo + QUO_BITS'(ia2d_corr(div_quo));
    oct = div_side.wide ? (DEG_90 - ANGLE_BITS'(adj)) : ANGLE_BITS'(adj);
    if (div_side.zero) begin
      angle_d = '0;
    end else if (div_side.yneg) begin
      angle_d = div_side.xneg ? (DEG_180 + oct) : (DEG_180 - oct);
    end else if (div_side.xneg) begin
      angle_d = DEG_360 - oct;
    end else begin
      angle_d = oct;
    end
  end

  assign en_f = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_f) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f && div_valid) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_deg_o = angle_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_deg_o <= DEG_360))
    else $error("angle out of range");

  a_empty_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_quo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && !div_side.zero) |-> (div_quo <= QUO_MAX))
    else $error("divider quotient above 45");

  a_out_follows_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && en_f) |=> out_valid_o)
    else $error("divider beat dropped at output");

endmodule
